// ===== rtl/seq_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted event queue package
// Shared constants, codes and types for the sorted event queue.
// ----------------------------------------------------------------------------
package seq_pkg;

	localparam int QUEUE_DEPTH = 64;
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int OCC_W       = 7;
	localparam int KIND_W      = 16;
	localparam int TIME_W      = 32;

	typedef enum logic {
		MODE_INSERT = 1'b0,
		MODE_POP    = 1'b1
	} mode_t;

	typedef enum logic [1:0] {
		STATUS_DONE  = 2'd0,
		STATUS_EMPTY = 2'd1,
		STATUS_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [TIME_W-1:0] ev_time;
	} entry_t;

	typedef struct packed {
		logic insert;
		logic pop;
	} cell_ctl_t;

endpackage

// ===== rtl/seq_cell.sv =====
// ----------------------------------------------------------------------------
// Sorted event queue cell
// One slot of the sorted shift queue. On an insert the cell keeps its event,
// takes the new event, or takes its left neighbor's event; on a pop it takes
// its right neighbor's event.
// ----------------------------------------------------------------------------
module seq_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  seq_pkg::cell_ctl_t ctl,
	input  seq_pkg::entry_t    new_entry,
	input  logic               prev_after,
	input  logic               prev_valid,
	input  seq_pkg::entry_t    prev_entry,
	input  logic               next_valid,
	input  seq_pkg::entry_t    next_entry,
	output logic               valid,
	output seq_pkg::entry_t    entry,
	output logic               after
);

	logic            valid_q;
	seq_pkg::entry_t entry_q;

	// The new event belongs behind this cell's event.
	assign after = valid_q && (entry_q.ev_time <= new_entry.ev_time);
	assign valid = valid_q;
	assign entry = entry_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.insert && !after) begin
			valid_q <= prev_after ? 1'b1 : prev_valid;
		end else if (ctl.pop) begin
			valid_q <= next_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.insert && !after) begin
			entry_q <= prev_after ? new_entry : prev_entry;
		end else if (ctl.pop) begin
			entry_q <= next_entry;
		end
	end

endmodule

// ===== rtl/sorted_event_queue.sv =====
// ----------------------------------------------------------------------------
// Sorted event queue
// The result beat is registered from each accepted input beat.
// Throughput: one insert or pop per cycle, set by the parallel compare in
// every cell of the shift queue; a stalled result beat holds the input.
// Reset clears the cell valid bits, the event count and the result register
// at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module sorted_event_queue (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          mode,
	input  logic [seq_pkg::KIND_W-1:0]    event_kind,
	input  logic [seq_pkg::TIME_W-1:0]    event_time,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [1:0]                    status,
	output logic [seq_pkg::KIND_W-1:0]    popped_kind,
	output logic [seq_pkg::TIME_W-1:0]    popped_time,
	output logic [seq_pkg::OCC_W-1:0]     occupancy
);

	localparam int D = seq_pkg::QUEUE_DEPTH;

	logic                         cell_valid [D];
	seq_pkg::entry_t              cell_entry [D];
	logic                         cell_after [D];
	seq_pkg::entry_t              new_entry;
	seq_pkg::cell_ctl_t           ctl;
	logic [seq_pkg::CNT_W-1:0]    count_q;
	logic [seq_pkg::CNT_W-1:0]    count_next;
	logic                         accept;
	logic                         full;
	logic                         empty;
	logic                         out_valid_q;
	seq_pkg::status_t             status_q;
	seq_pkg::status_t             status_next;
	seq_pkg::entry_t              popped_q;
	seq_pkg::entry_t              popped_next;
	logic [seq_pkg::OCC_W-1:0]    occupancy_q;

	assign in_ready  = !out_valid_q || out_ready;
	assign accept    = in_valid && in_ready;
	assign full      = (count_q == seq_pkg::CNT_W'(D));
	assign empty     = (count_q == '0);
	assign new_entry = '{kind: event_kind, ev_time: event_time};

	assign ctl.insert = accept && (mode == seq_pkg::MODE_INSERT) && !full;
	assign ctl.pop    = accept && (mode == seq_pkg::MODE_POP) && !empty;

	for (genvar i = 0; i < D; i++) begin : g_cell
		logic            p_after;
		logic            p_valid;
		seq_pkg::entry_t p_entry;
		logic            n_valid;
		seq_pkg::entry_t n_entry;

		if (i == 0) begin : g_head
			assign p_after = 1'b1;
			assign p_valid = 1'b0;
			assign p_entry = new_entry;
		end else begin : g_body
			assign p_after = cell_after[i-1];
			assign p_valid = cell_valid[i-1];
			assign p_entry = cell_entry[i-1];
		end

		if (i == D - 1) begin : g_tail
			assign n_valid = 1'b0;
			assign n_entry = new_entry;
		end else begin : g_inner
			assign n_valid = cell_valid[i+1];
			assign n_entry = cell_entry[i+1];
		end

		seq_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.new_entry  (new_entry),
			.prev_after (p_after),
			.prev_valid (p_valid),
			.prev_entry (p_entry),
			.next_valid (n_valid),
			.next_entry (n_entry),
			.valid      (cell_valid[i]),
			.entry      (cell_entry[i]),
			.after      (cell_after[i])
		);
	end

	always_comb begin
		count_next  = count_q;
		status_next = seq_pkg::STATUS_DONE;
		popped_next = '0;
		if (mode == seq_pkg::MODE_INSERT) begin
			if (full) begin
				status_next = seq_pkg::STATUS_FULL;
			end else begin
				count_next = count_q + seq_pkg::CNT_W'(1);
			end
		end else begin
			if (empty) begin
				status_next = seq_pkg::STATUS_EMPTY;
			end else begin
				count_next  = count_q - seq_pkg::CNT_W'(1);
				popped_next = cell_entry[0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
			status_q    <= seq_pkg::STATUS_DONE;
			popped_q    <= '0;
			occupancy_q <= '0;
		end else begin
			if (accept) begin
				count_q     <= count_next;
				out_valid_q <= 1'b1;
				status_q    <= status_next;
				popped_q    <= popped_next;
				occupancy_q <= seq_pkg::OCC_W'(count_next);
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign popped_kind = popped_q.kind;
	assign popped_time = popped_q.ev_time;
	assign occupancy   = occupancy_q;

endmodule
